/* hw/rtl/bdec_pkg.sv */
// Shared types, constants and helper functions for the binary to decimal ASCII converter.
`default_nettype none

package bdec_pkg;

    // Width of the number field on the input channel.
    localparam int unsigned NUM_BITS   = 64;
    // Width of one BCD digit and of one ASCII character on the output channel.
    localparam int unsigned BCD_W      = 4;
    localparam int unsigned CHAR_W     = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;
    // Double dabble correction: a digit of five or more gets three added before the shift.
    localparam logic [BCD_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [BCD_W-1:0] DABBLE_ADD   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Control from the sequencer to the digit register.
    typedef struct packed {
        logic load;
        logic conv;
        logic emit;
    } t_dab_ctl;

    // Number of decimal digits of 2^width - 1; 1233/4096 approximates log10(2).
    function automatic int unsigned dec_digits(input int unsigned width);
        return ((width * 1233) >> 12) + 1;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bdec_if.sv */
// Valid/ready channel interfaces for the number input and the character output.
`default_nettype none

interface bdec_num_if;
    logic                                valid;
    logic                                ready;
    logic [bdec_pkg::NUM_BITS-1:0]       number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface bdec_char_if;
    logic                                valid;
    logic                                ready;
    logic [bdec_pkg::CHAR_W-1:0]         digit_char;
    logic                                last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bdec_dabble.sv */
// Bit-serial double dabble datapath: binary shift register and a row of BCD digit cells.
`default_nettype none

module bdec_dabble #(
    parameter int unsigned NUMBER_WIDTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic [bdec_pkg::NUM_BITS-1:0]     i_number,
    input  wire bdec_pkg::t_dab_ctl                i_ctl,
    output logic [bdec_pkg::BCD_W-1:0]             o_top_digit
);

    localparam int unsigned NDIG = bdec_pkg::dec_digits(NUMBER_WIDTH);

    logic [NUMBER_WIDTH-1:0]        r_bin;
    logic [NUMBER_WIDTH-1:0]        n_bin;
    logic [bdec_pkg::BCD_W-1:0]     r_bcd [NDIG];
    logic [bdec_pkg::BCD_W-1:0]     n_bcd [NDIG];
    logic [bdec_pkg::BCD_W-1:0]     adj   [NDIG];

    // Each cell corrects its own digit before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (r_bcd[i] >= bdec_pkg::DABBLE_LIMIT) ?
                     r_bcd[i] + bdec_pkg::DABBLE_ADD : r_bcd[i];
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctl.load) begin
            n_bin = i_number[NUMBER_WIDTH-1:0];
            for (int i = 0; i < NDIG; i++) begin
                n_bcd[i] = '0;
            end
        end else if (i_ctl.conv) begin
            n_bin    = {r_bin[NUMBER_WIDTH-2:0], 1'b0};
            n_bcd[0] = {adj[0][bdec_pkg::BCD_W-2:0], r_bin[NUMBER_WIDTH-1]};
            for (int i = 1; i < NDIG; i++) begin
                n_bcd[i] = {adj[i][bdec_pkg::BCD_W-2:0], adj[i-1][bdec_pkg::BCD_W-1]};
            end
        end else if (i_ctl.emit) begin
            // Move the digits up one place so the next one reaches the top.
            n_bcd[0] = '0;
            for (int i = 1; i < NDIG; i++) begin
                n_bcd[i] = r_bcd[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[NDIG-1];

endmodule

`default_nettype wire

/* hw/rtl/bdec_ctrl.sv */
// Sequencer: shift counting, digit scan with leading-zero suppression, output register.
`default_nettype none

module bdec_ctrl #(
    parameter int unsigned NUMBER_WIDTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [bdec_pkg::CHAR_W-1:0]            o_digit_char,
    output logic                                   o_last_digit,
    input  wire logic [bdec_pkg::BCD_W-1:0]        i_top_digit,
    output bdec_pkg::t_dab_ctl                     o_ctl
);

    localparam int unsigned NDIG   = bdec_pkg::dec_digits(NUMBER_WIDTH);
    localparam int unsigned CNT_W  = $clog2(NUMBER_WIDTH);
    localparam int unsigned DCNT_W = $clog2(NDIG);

    bdec_pkg::t_state               r_state, n_state;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic [DCNT_W-1:0]              r_dcnt, n_dcnt;
    logic                           r_seen, n_seen;
    logic                           r_oval, n_oval;
    logic [bdec_pkg::CHAR_W-1:0]    r_char, n_char;
    logic                           r_last, n_last;

    logic                           conv_done;
    logic                           adv;
    logic                           is_last;
    logic                           take;

    assign conv_done = (r_cnt == CNT_W'(NUMBER_WIDTH - 1));
    assign is_last   = (r_dcnt == '0);
    assign adv       = !r_oval || i_out_ready;
    assign take      = (i_top_digit != '0) || r_seen || is_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdec_pkg::ST_IDLE: if (i_in_valid) n_state = bdec_pkg::ST_CONV;
            bdec_pkg::ST_CONV: if (conv_done)  n_state = bdec_pkg::ST_EMIT;
            bdec_pkg::ST_EMIT: if (adv && is_last) n_state = bdec_pkg::ST_IDLE;
            default:           n_state = bdec_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            bdec_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            bdec_pkg::ST_CONV: o_ctl.conv = 1'b1;
            bdec_pkg::ST_EMIT: o_ctl.emit = adv;
            default: ;
        endcase
    end

    // Counters, flags and output register.
    always_comb begin
        n_cnt  = r_cnt;
        n_dcnt = r_dcnt;
        n_seen = r_seen;
        n_oval = r_oval && !i_out_ready;
        n_char = r_char;
        n_last = r_last;
        if (o_ctl.load) begin
            n_cnt = '0;
        end
        if (o_ctl.conv) begin
            n_cnt = r_cnt + 1'b1;
            if (conv_done) begin
                n_dcnt = DCNT_W'(NDIG - 1);
                n_seen = 1'b0;
            end
        end
        if (o_ctl.emit) begin
            n_dcnt = r_dcnt - 1'b1;
            if (take) begin
                n_oval = 1'b1;
                n_char = bdec_pkg::ASCII_ZERO + {2'b00, i_top_digit};
                n_last = is_last;
                n_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdec_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_dcnt  <= '0;
            r_seen  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dcnt  <= n_dcnt;
            r_seen  <= n_seen;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid  = r_oval;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

    // A new beat is only ever loaded while digits are being scanned.
    a_rise_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_oval) |-> $past(r_state == bdec_pkg::ST_EMIT))
        else $error("output beat appeared outside the digit scan");

    // A waiting beat always holds a decimal digit character.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> (r_char >= bdec_pkg::ASCII_ZERO && r_char <= bdec_pkg::ASCII_NINE))
        else $error("output character is not a decimal digit");

    // Finishing the scan leaves the final digit flagged in the output register.
    a_end_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bdec_pkg::ST_EMIT && n_state == bdec_pkg::ST_IDLE) |=> (r_oval && r_last))
        else $error("digit scan ended without a flagged last digit");

    // The conversion phase is not left before the shift counter signals that it is done.
    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bdec_pkg::ST_CONV && !conv_done) |=> (r_state == bdec_pkg::ST_CONV))
        else $error("conversion left early");

endmodule

`default_nettype wire

/* hw/rtl/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter.
//
//  Channel  | Dir | Payload                                   | Meaning
//  ---------+-----+-------------------------------------------+-------------------------------
//  i_num    | in  | number[63:0]                              | one value to convert per beat
//  o_char   | out | digit_char[5:0], last_digit               | one ASCII digit per beat
//
// Operation: after the input beat is taken, bit-serial double dabble shifts the whole number
// through the BCD digit cells, one input bit per cycle. The digit register is then scanned
// from the most significant place, one digit per cycle while the output is not stalled, over
// all dec_digits(NUMBER_WIDTH) places (20 at width 64); leading zeros are dropped without a beat.
// A stalled output beat holds the scan. Reset is synchronous and active low; it clears the
// sequencer and the output valid flag. The input ready is high only while the block is idle,
// so one number is in flight at a time.
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int unsigned NUMBER_WIDTH = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdec_num_if.sink    i_num,
    bdec_char_if.source o_char
);

    bdec_pkg::t_dab_ctl             ctl;
    logic [bdec_pkg::BCD_W-1:0]     top_digit;

    // Datapath: input shift register and the BCD digit cells.
    bdec_dabble #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dabble (
        .i_clk       (i_clk),
        .i_number    (i_num.number),
        .i_ctl       (ctl),
        .o_top_digit (top_digit)
    );

    // Sequencer and the registered output beat.
    bdec_ctrl #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_num.valid),
        .o_in_ready   (i_num.ready),
        .i_out_ready  (o_char.ready),
        .o_out_valid  (o_char.valid),
        .o_digit_char (o_char.digit_char),
        .o_last_digit (o_char.last_digit),
        .i_top_digit  (top_digit),
        .o_ctl        (ctl)
    );

endmodule

`default_nettype wire

/* tb/binary_to_decimal_ascii_tb.sv */
// Self-checking testbench for binary_to_decimal_ascii: numbers in, decimal digits checked out.
`default_nettype none

module binary_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Width converted by the block under test; input bits above it are ignored.
    localparam int unsigned NUMBER_WIDTH = 64;
    // Length of the deliberate output hold-off, in clock cycles.
    localparam int unsigned LONG_STALL   = 400;
    // Quiet cycles after the last digit.
    localparam int unsigned DRAIN_CYCLES = 120;
    // Random numbers sent in each of the three idling phases.
    localparam int unsigned RANDOM_PER_PHASE = 62;

    // One character beat on the output channel.
    typedef struct packed {
        logic [bdec_pkg::CHAR_W-1:0] digit_char;
        logic                        last_digit;
    } t_char_beat;

    // Predicts the decimal text of every accepted number and checks each
    // output beat against the oldest predicted character.
    class decimal_text_checker;
        t_char_beat expected_chars[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        // Splits the number into decimal digits and queues their characters,
        // most significant first, with the flag on the units digit.
        function void note_number(logic [63:0] value);
            logic [63:0] rest;
            logic [3:0]  digits[$];
            t_char_beat  beat;
            rest = value & ({64{1'b1}} >> (64 - NUMBER_WIDTH));
            // Zero still yields one digit, because the loop body runs once.
            do begin
                digits.push_front(4'(rest % 64'd10));
                rest = rest / 64'd10;
            end while (rest != 64'd0);
            foreach (digits[i]) begin
                beat.digit_char = bdec_pkg::ASCII_ZERO + bdec_pkg::CHAR_W'(digits[i]);
                beat.last_digit = (i == digits.size() - 1);
                expected_chars.push_back(beat);
            end
        endfunction

        function void check_char(logic [bdec_pkg::CHAR_W-1:0] digit_char, logic last_digit);
            t_char_beat want;
            if (expected_chars.size() == 0) begin
                $error("unexpected beat: digit_char %0d, last_digit %0b",
                       digit_char, last_digit);
                fail_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (digit_char !== want.digit_char) begin
                $error("digit_char mismatch: expected %0d, actual %0d",
                       want.digit_char, digit_char);
                fail_count++;
            end
            if (last_digit !== want.last_digit) begin
                $error("last_digit mismatch: expected %0b, actual %0b",
                       want.last_digit, last_digit);
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bdec_num_if  num_ch();
    bdec_char_if char_ch();

    binary_to_decimal_ascii #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_num  (num_ch),
        .o_char (char_ch)
    );

    decimal_text_checker text_checker = new();

    // Idling odds, in percent of cycles, set per phase by the stimulus.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit          long_stall_req;
    int unsigned stall_left;

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on the whole run. The slowest legal run is far below this:
    // about 210 numbers, each a full conversion plus up to twenty digit beats that
    // may each wait out a random receiver stall, plus one long hold-off.
    initial begin
        #10_000_000;
        $display("binary_to_decimal_ascii verification failed");
        $finish;
    end

    // Both monitors sample at the rising edge, where every signal still holds
    // the value it had before the edge, so the outcome does not depend on
    // process order within the time step.
    always @(posedge i_clk) begin
        if (i_rst_n && num_ch.valid && num_ch.ready) begin
            text_checker.note_number(num_ch.number);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            text_checker.check_char(char_ch.digit_char, char_ch.last_digit);
        end
    end

    // Receiver: drops ready at random, or for a long counted stretch when
    // asked. During that stretch the block cannot finish its number, so its
    // input ready stays low while the sender keeps offering the next beat.
    initial begin
        stall_left = 0;
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && long_stall_req) begin
                stall_left     = LONG_STALL;
                long_stall_req = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                char_ch.ready <= 1'b0;
            end else begin
                char_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one number and returns at the edge where the beat is taken.
    // Valid is only lowered when the sender actually idles, so back-to-back
    // beats never see valid dropped and raised in the same time step.
    task automatic send_number(input logic [63:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            num_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        num_ch.valid  <= 1'b1;
        num_ch.number <= value;
        do @(posedge i_clk); while (!num_ch.ready);
    endtask

    function automatic logic [63:0] power_of_ten(input int unsigned exponent);
        logic [63:0] p;
        p = 64'd1;
        repeat (exponent) p = p * 64'd10;
        return p;
    endfunction

    // Random numbers spread over every digit count: full-width values, values
    // cut to a random bit length, values around a power of ten (where the
    // digit count changes) and small values.
    function automatic logic [63:0] random_number();
        logic [63:0] value;
        case ($urandom_range(3))
            0: value = {$urandom, $urandom};
            1: value = {$urandom, $urandom} >> $urandom_range(63);
            2: value = power_of_ten($urandom_range(1, 19)) + 64'($urandom_range(6)) - 64'd3;
            default: value = 64'($urandom_range(1000));
        endcase
        return value;
    endfunction

    initial begin
        logic [63:0] corner_numbers[$];

        // Every input is known from time zero, while reset is held asserted.
        i_rst_n        <= 1'b0;
        num_ch.valid   <= 1'b0;
        num_ch.number  <= '0;
        long_stall_req  = 1'b0;
        send_idle_pct   = 6;
        recv_idle_pct   = 68;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner numbers: zero gives the single character, single digits and
        // the step to two digits, the largest 19-digit value and the first
        // 20-digit one, the full-scale value, the sign bit on its own and the
        // alternating bit patterns.
        corner_numbers = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
            64'd1_000_000_000_000_000_000,
            64'd9_999_999_999_999_999_999,
            64'd10_000_000_000_000_000_000,
            64'd12_345_678_901_234_567_890,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
            64'd4_294_967_295, 64'd100_000_000_000_000_000
        };
        foreach (corner_numbers[i]) send_number(corner_numbers[i]);

        // Three idling phases: sender rarely idles while the receiver often
        // stalls, then the reverse, then neither side idles at all.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 6;  recv_idle_pct = 68; end
                1: begin send_idle_pct = 68; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // One long output hold-off, with the sender still pushing.
                if (phase == 0 && n == 20) long_stall_req = 1'b1;
                send_number(random_number());
            end
        end
        num_ch.valid <= 1'b0;

        // Let the last number drain, then watch for stray beats.
        while (text_checker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (text_checker.fail_count == 0 && text_checker.pending() == 0) begin
            $display("binary_to_decimal_ascii verification clean");
        end else begin
            $display("binary_to_decimal_ascii verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/bdec_pkg.sv
hw/rtl/bdec_if.sv
hw/rtl/bdec_dabble.sv
hw/rtl/bdec_ctrl.sv
hw/rtl/binary_to_decimal_ascii.sv
tb/binary_to_decimal_ascii_tb.sv
